>>> hdl/mtf_pkg.sv
// ---------------------------------------------------------------------------
// mtf_pkg
// Shared types, constants and elaboration helpers for the move-to-front
// rank tracker.
// ---------------------------------------------------------------------------
package mtf_pkg;

    localparam int ELEM_W           = 10;
    localparam int POS_W            = 11;
    localparam int LEN_W            = 11;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 40;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int TREE_RADIX       = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } state_t;

    // node count at a given level of the radix reduction tree
    function automatic int level_nodes(input int n, input int lvl);
        int m;
        m = n;
        for (int i = 0; i < lvl; i++) begin
            m = (m + TREE_RADIX - 1) / TREE_RADIX;
        end
        return m;
    endfunction

    function automatic int tree_levels(input int n);
        int m;
        int l;
        m = n;
        l = 0;
        while (m > 1) begin
            m = (m + TREE_RADIX - 1) / TREE_RADIX;
            l = l + 1;
        end
        return (l < 1) ? 1 : l;
    endfunction

endpackage

>>> hdl/move_to_front_rank_tracker.sv
// ---------------------------------------------------------------------------
// move_to_front_rank_tracker
// Move-to-front list with per-element best/worst position tracking.
// Input stream: s_tuser = kind (0 access and move to front, 1 report),
// s_tdata = element index. Output stream: one result per input transfer,
// m_tdata = {worst_position, best_position, position}, m_tuser = error.
// Config channel cfg_valid/cfg_ready/cfg_data writes list_length; cfg_ready
// is always high; write only while the block is idle.
// The list is a row of MAX_ELEMENTS cells, one per position. A lookup
// compares the element in every cell at once and reduces the one-hot hit
// through a registered radix-16 tree of L = ceil(log16(MAX_ELEMENTS)) levels
// (3 at 1024). The search state runs the lookup through the tree levels,
// then the apply state loads the result; only then, back in idle, is a new
// item taken. A rejected element skips the lookup and goes to apply.
// On an access the cells up to the hit take their neighbor's entry together
// as the result is loaded; the accessed element enters the front cell.
// Reset (synchronous, active low) puts element i at position i with best and
// worst at i, and list_length at 1024. A stalled m_tready holds the result;
// one further item may be taken and worked up to its result, then it waits.
// ---------------------------------------------------------------------------
module move_to_front_rank_tracker #(
    parameter int MAX_ELEMENTS = mtf_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mtf_pkg::S_TDATA_W-1:0]  s_tdata,  // [9:0] element
    input  logic [0:0]                     s_tuser,  // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mtf_pkg::M_TDATA_W-1:0]  m_tdata,  // [10:0] position,
                                                     // [21:11] best_position,
                                                     // [32:22] worst_position
    output logic [0:0]                     m_tuser,  // [0] error
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mtf_pkg::LEN_W-1:0]      cfg_data
);

    localparam int IDW    = $clog2(MAX_ELEMENTS);
    localparam int W      = 2 * IDW + 1;
    localparam int LEVELS = mtf_pkg::tree_levels(MAX_ELEMENTS);
    localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int POS_W  = mtf_pkg::POS_W;

    mtf_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [mtf_pkg::LEN_W-1:0]    len_reg;
    logic [mtf_pkg::ELEM_W-1:0]   x_reg;
    logic                         kind_reg;
    logic                         err_reg;
    logic                         m_valid_reg;
    logic [POS_W-1:0]             pos_out_reg, best_out_reg, worst_out_reg;
    logic                         err_out_reg;

    logic                         s_xfer;
    logic                         load;
    logic                         move_en;
    logic [mtf_pkg::ELEM_W-1:0]   s_elem;
    logic                         s_err;
    logic [IDW-1:0]               query;
    logic [W-1:0]                 root;
    logic [IDW-1:0]               hit_pos;
    logic                         hit_acc;
    logic [IDW-1:0]               hit_worst;
    logic [IDW-1:0]               wmax;
    logic [POS_W-1:0]             pos1, worst1, best1;

    logic [IDW-1:0] cid    [MAX_ELEMENTS];
    logic           cacc   [MAX_ELEMENTS];
    logic [IDW-1:0] cworst [MAX_ELEMENTS];
    logic [W-1:0]   leaf   [MAX_ELEMENTS];

    assign s_elem   = s_tdata[mtf_pkg::ELEM_W-1:0];
    assign s_err    = ({1'b0, s_elem} >= len_reg) || (int'(s_elem) >= MAX_ELEMENTS);
    assign s_tready = (state_reg == mtf_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign load     = (state_reg == mtf_pkg::ST_APPLY) && (!m_valid_reg || m_tready);
    assign move_en  = load && !err_reg && (kind_reg == mtf_pkg::KIND_ACCESS);
    assign query    = IDW'(x_reg);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= mtf_pkg::LEN_RESET;
        end else if (cfg_valid) begin
            len_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtf_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            mtf_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_xfer) begin
                    state_next = s_err ? mtf_pkg::ST_APPLY : mtf_pkg::ST_SEARCH;
                end
            end
            mtf_pkg::ST_SEARCH: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LEVELS - 1)) begin
                    state_next = mtf_pkg::ST_APPLY;
                end
            end
            mtf_pkg::ST_APPLY: begin
                if (load) begin
                    state_next = mtf_pkg::ST_IDLE;
                end
            end
            default: state_next = mtf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            x_reg    <= s_elem;
            kind_reg <= s_tuser[0];
            err_reg  <= s_err;
        end
    end

    for (genvar j = 0; j < MAX_ELEMENTS; j++) begin : g_cell
        logic [IDW-1:0] p_id;
        logic           p_acc;
        logic [IDW-1:0] p_worst;
        if (j == 0) begin : g_front
            assign p_id    = query;
            assign p_acc   = 1'b1;
            assign p_worst = wmax;
        end else begin : g_link
            assign p_id    = cid[j-1];
            assign p_acc   = cacc[j-1];
            assign p_worst = cworst[j-1];
        end
        mtf_cell #(
            .IDW   (IDW),
            .INDEX (j)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .move_en    (move_en),
            .move_pos   (hit_pos),
            .query      (query),
            .prev_id    (p_id),
            .prev_acc   (p_acc),
            .prev_worst (p_worst),
            .id_o       (cid[j]),
            .acc_o      (cacc[j]),
            .worst_o    (cworst[j]),
            .leaf_o     (leaf[j])
        );
    end

    mtf_tree #(
        .N (MAX_ELEMENTS),
        .W (W)
    ) u_tree (
        .aclk   (aclk),
        .leaf_i (leaf),
        .root_o (root)
    );

    assign hit_pos   = root[2*IDW:IDW+1];
    assign hit_acc   = root[IDW];
    assign hit_worst = root[IDW-1:0];
    assign wmax      = (hit_worst > hit_pos) ? hit_worst : hit_pos;
    assign pos1      = POS_W'({1'b0, hit_pos} + 1'b1);
    assign worst1    = POS_W'({1'b0, wmax} + 1'b1);
    assign best1     = (hit_acc || (kind_reg == mtf_pkg::KIND_ACCESS))
                     ? POS_W'(1) : (POS_W'(x_reg) + POS_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            err_out_reg <= err_reg;
            if (err_reg) begin
                pos_out_reg   <= '0;
                best_out_reg  <= '0;
                worst_out_reg <= '0;
            end else begin
                pos_out_reg   <= pos1;
                best_out_reg  <= best1;
                worst_out_reg <= worst1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, worst_out_reg, best_out_reg, pos_out_reg};
    assign m_tuser  = err_out_reg;

endmodule

>>> hdl/mtf_cell.sv
// ---------------------------------------------------------------------------
// mtf_cell
// One list position: holds the element standing there with its accessed
// flag and worst position, and takes its neighbor's entry on a move.
// ---------------------------------------------------------------------------
module mtf_cell #(
    parameter int IDW   = 10,
    parameter int INDEX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           move_en,
    input  logic [IDW-1:0] move_pos,
    input  logic [IDW-1:0] query,
    input  logic [IDW-1:0] prev_id,
    input  logic           prev_acc,
    input  logic [IDW-1:0] prev_worst,
    output logic [IDW-1:0] id_o,
    output logic           acc_o,
    output logic [IDW-1:0] worst_o,
    output logic [2*IDW:0] leaf_o
);

    localparam logic [IDW-1:0] MY_POS = IDW'(INDEX);

    logic [IDW-1:0] id_reg;
    logic           acc_reg;
    logic [IDW-1:0] worst_reg;
    logic           take;

    assign take = move_en && (MY_POS <= move_pos);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg    <= MY_POS;
            acc_reg   <= 1'b0;
            worst_reg <= MY_POS;
        end else if (take) begin
            id_reg    <= prev_id;
            acc_reg   <= prev_acc;
            worst_reg <= prev_worst;
        end
    end

    assign id_o    = id_reg;
    assign acc_o   = acc_reg;
    assign worst_o = worst_reg;
    assign leaf_o  = (id_reg == query) ? {MY_POS, acc_reg, worst_reg} : '0;

endmodule

>>> hdl/mtf_tree.sv
// ---------------------------------------------------------------------------
// mtf_tree
// Registered radix-16 OR tree; picks the single nonzero leaf (one-hot hit)
// out of the cell row, one tree level per cycle.
// ---------------------------------------------------------------------------
module mtf_tree #(
    parameter int N = 1024,
    parameter int W = 21
) (
    input  logic         aclk,
    input  logic [W-1:0] leaf_i [N],
    output logic [W-1:0] root_o
);

    localparam int LEVELS = mtf_pkg::tree_levels(N);
    localparam int R      = mtf_pkg::TREE_RADIX;

    logic [W-1:0] node [LEVELS+1][N];

    for (genvar j = 0; j < N; j++) begin : g_leaf
        assign node[0][j] = leaf_i[j];
    end

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int CNT  = mtf_pkg::level_nodes(N, l);
        localparam int PREV = mtf_pkg::level_nodes(N, l - 1);
        for (genvar k = 0; k < CNT; k++) begin : g_node
            logic [W-1:0] part [R];
            logic [W-1:0] sum;
            logic [W-1:0] sum_reg;
            for (genvar c = 0; c < R; c++) begin : g_child
                if (k * R + c < PREV) begin : g_real
                    assign part[c] = node[l-1][k*R+c];
                end else begin : g_pad
                    assign part[c] = '0;
                end
            end
            always_comb begin
                sum = '0;
                for (int c = 0; c < R; c++) begin
                    sum = sum | part[c];
                end
            end
            always_ff @(posedge aclk) begin
                sum_reg <= sum;
            end
            assign node[l][k] = sum_reg;
        end
    end

    assign root_o = node[LEVELS][0];

endmodule

>>> dv/mtf_rank_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtf_rank_checker
// Watches the input, result and length-write channels of the rank tracker,
// keeps its own move-to-front list with best and worst positions, and checks
// every result transfer against the oldest predicted result in order.
// ---------------------------------------------------------------------------
module mtf_rank_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [mtf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [mtf_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [0:0]                    m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mtf_pkg::LEN_W-1:0]     cfg_data,
    output int                            pending,
    output int                            mismatches
);

    localparam int LIST_SIZE = mtf_pkg::MAX_ELEMENTS_DEF;
    localparam int POS_W     = mtf_pkg::POS_W;
    localparam int ELEM_W    = mtf_pkg::ELEM_W;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] best;
        logic [POS_W-1:0] worst;
        logic             error;
    } rank_result_t;

    logic [ELEM_W-1:0]         rank_of  [LIST_SIZE];
    logic [ELEM_W-1:0]         best_of  [LIST_SIZE];
    logic [ELEM_W-1:0]         worst_of [LIST_SIZE];
    logic [mtf_pkg::LEN_W-1:0] list_len = mtf_pkg::LEN_RESET;

    rank_result_t rank_results_q[$];
    int           open_cnt = 0;
    int           fail_cnt = 0;

    assign pending    = open_cnt;
    assign mismatches = fail_cnt;

    // one item through the list: returns the result and, on an access, updates the tables
    function automatic rank_result_t next_rank_result(input logic kind,
                                                      input logic [ELEM_W-1:0] elem);
        rank_result_t      res;
        int                in_use;
        logic [ELEM_W-1:0] pos;
        logic [ELEM_W-1:0] hi;
        in_use = (list_len > LIST_SIZE) ? LIST_SIZE : int'(list_len);
        res = '0;
        if (int'(elem) >= in_use) begin
            res.error = 1'b1;
            return res;
        end
        pos = rank_of[elem];
        if (kind == mtf_pkg::KIND_REPORT) begin
            hi = (worst_of[elem] > pos) ? worst_of[elem] : pos;
            res.position = POS_W'(pos) + POS_W'(1);
            res.best     = POS_W'(best_of[elem]) + POS_W'(1);
            res.worst    = POS_W'(hi) + POS_W'(1);
            return res;
        end
        for (int i = 0; i < LIST_SIZE; i++) begin
            if (rank_of[i] < pos) rank_of[i] = rank_of[i] + ELEM_W'(1);
        end
        rank_of[elem] = '0;
        best_of[elem] = '0;
        if (pos > worst_of[elem]) worst_of[elem] = pos;
        res.position = POS_W'(pos) + POS_W'(1);
        res.best     = POS_W'(1);
        res.worst    = POS_W'(worst_of[elem]) + POS_W'(1);
        return res;
    endfunction

    task automatic log_failure(input string what, input rank_result_t want,
                               input rank_result_t got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s: expected pos=%0d best=%0d worst=%0d err=%0b,",
                     $realtime, what, want.position, want.best, want.worst,
                     want.error);
            $display("    got pos=%0d best=%0d worst=%0d err=%0b",
                     got.position, got.best, got.worst, got.error);
        end
    endtask

    always @(posedge aclk) begin
        rank_result_t want;
        rank_result_t got;
        rank_result_t pred;
        if (!aresetn) begin
            for (int i = 0; i < LIST_SIZE; i++) begin
                rank_of[i]  = ELEM_W'(i);
                best_of[i]  = ELEM_W'(i);
                worst_of[i] = ELEM_W'(i);
            end
            list_len = mtf_pkg::LEN_RESET;
            rank_results_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                pred = next_rank_result(s_tuser[0], s_tdata[ELEM_W-1:0]);
                rank_results_q.insert(rank_results_q.size(), pred);
            end
            if (cfg_valid && cfg_ready) list_len = cfg_data;
            if (m_tvalid && m_tready) begin
                got.position = m_tdata[POS_W-1:0];
                got.best     = m_tdata[2*POS_W-1:POS_W];
                got.worst    = m_tdata[3*POS_W-1:2*POS_W];
                got.error    = m_tuser[0];
                if (rank_results_q.size() == 0) begin
                    log_failure("unexpected result", '0, got);
                end else begin
                    want = rank_results_q.pop_front();
                    if (got.position !== want.position || got.best !== want.best ||
                        got.worst !== want.worst || got.error !== want.error) begin
                        log_failure("result mismatch", want, got);
                    end
                end
            end
        end
        open_cnt <= rank_results_q.size();
    end

endmodule

>>> dv/move_to_front_rank_tracker_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// move_to_front_rank_tracker_tb
// Drives accesses and reports into the rank tracker across a range of list
// lengths with random idle cycles on both streams, bar one phase without;
// a checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module move_to_front_rank_tracker_tb;

    localparam int ELEM_W    = mtf_pkg::ELEM_W;
    localparam int LEN_W     = mtf_pkg::LEN_W;
    localparam int S_TDATA_W = mtf_pkg::S_TDATA_W;
    localparam int M_TDATA_W = mtf_pkg::M_TDATA_W;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LEN_W-1:0]     cfg_data  = '0;

    int pending;
    int mismatches;
    bit no_idle = 1'b0;

    always #5 aclk = ~aclk;

    move_to_front_rank_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mtf_rank_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 23);
    end

    task automatic send_item(input logic kind, input logic [ELEM_W-1:0] elem);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 23) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(elem);
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    // list length only changes with the block drained
    task automatic set_length(input logic [LEN_W-1:0] len);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int unsigned       phase_len [11];
        int                cur_eff;
        int                pick;
        int                sel;
        logic              kind;
        logic [ELEM_W-1:0] recent[$];

        phase_len = '{1024, 16, 1, 2047, 100, 2, 513, 0, 1023, 37, 1024};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset length, list ends and repeated accesses
        send_item(mtf_pkg::KIND_REPORT, 10'd0);
        send_item(mtf_pkg::KIND_REPORT, 10'd1023);
        send_item(mtf_pkg::KIND_ACCESS, 10'd1023);
        send_item(mtf_pkg::KIND_ACCESS, 10'd1023);
        send_item(mtf_pkg::KIND_REPORT, 10'd1023);
        send_item(mtf_pkg::KIND_ACCESS, 10'd0);
        send_item(mtf_pkg::KIND_REPORT, 10'd0);
        send_item(mtf_pkg::KIND_ACCESS, 10'd341);
        send_item(mtf_pkg::KIND_ACCESS, 10'd682);
        send_item(mtf_pkg::KIND_REPORT, 10'd1023);
        // short list: out-of-range elements
        set_length(11'd5);
        send_item(mtf_pkg::KIND_ACCESS, 10'd4);
        send_item(mtf_pkg::KIND_ACCESS, 10'd5);
        send_item(mtf_pkg::KIND_REPORT, 10'd1023);
        send_item(mtf_pkg::KIND_ACCESS, 10'd1023);
        send_item(mtf_pkg::KIND_REPORT, 10'd4);
        // zero length rejects everything
        set_length(11'd0);
        send_item(mtf_pkg::KIND_ACCESS, 10'd0);
        send_item(mtf_pkg::KIND_REPORT, 10'd0);
        // oversize length clamps to the full list
        set_length(11'd2047);
        send_item(mtf_pkg::KIND_ACCESS, 10'd700);
        send_item(mtf_pkg::KIND_REPORT, 10'd1023);
        set_length(11'd1);
        send_item(mtf_pkg::KIND_ACCESS, 10'd0);
        send_item(mtf_pkg::KIND_REPORT, 10'd0);
        send_item(mtf_pkg::KIND_ACCESS, 10'd1);

        for (int ph = 0; ph < 11; ph++) begin
            set_length(LEN_W'(phase_len[ph]));
            cur_eff = (phase_len[ph] > mtf_pkg::MAX_ELEMENTS_DEF)
                    ? mtf_pkg::MAX_ELEMENTS_DEF : int'(phase_len[ph]);
            no_idle <= (ph == 4);
            repeat ((phase_len[ph] == 0) ? 30 : 160) begin
                sel = $urandom_range(0, 99);
                if (cur_eff == 0 || sel < 10) begin
                    pick = $urandom_range(0, 1023);
                end else if (sel < 20 && cur_eff < mtf_pkg::MAX_ELEMENTS_DEF) begin
                    pick = cur_eff + $urandom_range(0, 3);
                    if (pick > 1023) pick = 1023;
                end else if (sel < 45 && recent.size() > 0) begin
                    pick = recent[$urandom_range(0, recent.size() - 1)];
                end else if (sel < 70) begin
                    pick = $urandom_range(0, ((cur_eff < 32) ? cur_eff : 32) - 1);
                end else begin
                    pick = $urandom_range(0, cur_eff - 1);
                end
                kind = ($urandom_range(0, 99) < 60) ? mtf_pkg::KIND_ACCESS
                                                   : mtf_pkg::KIND_REPORT;
                send_item(kind, pick[ELEM_W-1:0]);
                if (kind == mtf_pkg::KIND_ACCESS) begin
                    recent = {recent, pick[ELEM_W-1:0]};
                    if (recent.size() > 8) void'(recent.pop_front());
                end
            end
        end

        s_tvalid <= 1'b0;
        no_idle  <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("** move_to_front_rank_tracker: PASSED **");
        end else begin
            $display("** move_to_front_rank_tracker: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("** move_to_front_rank_tracker: FAILED **");
        $finish;
    end

endmodule
